// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usbhid check failed");

// Next-cycle implication, off while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usbhid check failed");

`endif

// ===== rtl/usbhid_pkg.sv =====
package usbhid_pkg;

  localparam int CONTROL_PACKET_BYTES = 8;
  localparam int REPORT_PACKET_BYTES  = 64;

  // transfer state codes
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DEVICE   = 4'd1;
  localparam logic [3:0] ST_CFG_FULL = 4'd2;
  localparam logic [3:0] ST_CFG_HEAD = 4'd3;
  localparam logic [3:0] ST_STR0     = 4'd4;
  localparam logic [3:0] ST_STR1     = 4'd5;
  localparam logic [3:0] ST_STR2     = 4'd6;
  localparam logic [3:0] ST_STR3     = 4'd7;
  localparam logic [3:0] ST_REPORT   = 4'd8;

  // request type field (bits 6..5 of bmRequestType)
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;

  localparam logic [7:0] RQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] RQ_SET_IDLE          = 8'h0A;

  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_REPORT = 8'h22;

  localparam logic [7:0] ADDR_ENABLE = 8'h80;
  localparam logic [15:0] CFG_HEAD_LEN = 16'd9;

  // configuration register indexes
  localparam logic [1:0] REG_VENDOR_ID     = 2'd0;
  localparam logic [1:0] REG_PRODUCT_ID    = 2'd1;
  localparam logic [1:0] REG_MAX_POWER     = 2'd2;
  localparam logic [1:0] REG_POLL_INTERVAL = 2'd3;

  localparam logic [15:0] VENDOR_ID_RESET     = 16'h5345;
  localparam logic [15:0] PRODUCT_ID_RESET    = 16'h1234;
  localparam logic [7:0]  MAX_POWER_RESET     = 8'h31;
  localparam logic [7:0]  POLL_INTERVAL_RESET = 8'h0A;

  // descriptor lengths
  localparam logic [5:0] LEN_DEVICE   = 6'd18;
  localparam logic [5:0] LEN_CFG_HEAD = 6'd9;
  localparam logic [5:0] LEN_CFG_FULL = 6'd34;
  localparam logic [5:0] LEN_STR0     = 6'd4;
  localparam logic [5:0] LEN_STR1     = 6'd22;
  localparam logic [5:0] LEN_STR2     = 6'd44;
  localparam logic [5:0] LEN_STR3     = 6'd20;
  localparam logic [5:0] LEN_REPORT   = 6'd52;

  // fixed descriptor images; register-driven bytes are patched in the ROM
  localparam logic [7:0] DEV_ROM [18] = '{
    8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'(CONTROL_PACKET_BYTES),
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01
  };

  localparam logic [7:0] CFG_ROM [34] = '{
    8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h00,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h02, 8'h00,
    8'h09, 8'h21, 8'h10, 8'h01, 8'h21, 8'h01, 8'h22, 8'h34, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'(REPORT_PACKET_BYTES), 8'h00, 8'h00
  };

  localparam logic [7:0] REPORT_ROM [52] = '{
    8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01, 8'h09, 8'h01, 8'hA1, 8'h00,
    8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h03, 8'h15, 8'h00, 8'h25, 8'h01,
    8'h95, 8'h03, 8'h75, 8'h01, 8'h81, 8'h02, 8'h95, 8'h01, 8'h75, 8'h05,
    8'h81, 8'h01, 8'h05, 8'h01, 8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h38,
    8'h15, 8'h81, 8'h25, 8'h7F, 8'h75, 8'h08, 8'h95, 8'h03, 8'h81, 8'h06,
    8'hC0, 8'hC0
  };

  localparam logic [7:0] TEXT1 [10] = '{
    8'h53, 8'h79, 8'h73, 8'h74, 8'h65, 8'h6D, 8'h20, 8'h4D, 8'h43, 8'h55
  };

  localparam logic [7:0] TEXT2 [21] = '{
    8'h53, 8'h45, 8'h43, 8'h20, 8'h53, 8'h33, 8'h43, 8'h32, 8'h34, 8'h31,
    8'h30, 8'h58, 8'h20, 8'h54, 8'h65, 8'h73, 8'h74, 8'h20, 8'h42, 8'h2F,
    8'h44
  };

  localparam logic [7:0] TEXT3 [9] = '{
    8'h55, 8'h53, 8'h42, 8'h4D, 8'h4F, 8'h55, 8'h53, 8'h45, 8'h20
  };

  typedef struct packed {
    logic        early_end;
    logic        sent_stall;
    logic        out_ready;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [15:0] request_length;
  } req_t;

  typedef struct packed {
    logic [63:0] packet_data;
    logic [3:0]  packet_bytes;
    logic        send_packet;
    logic        stage_end;
    logic        clear_out_ready;
    logic        clear_early_end;
    logic        clear_sent_stall;
    logic        address_write;
    logic [7:0]  device_address;
    logic        configured;
    logic [7:0]  config_value;
  } rsp_t;

  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [7:0]  max_power;
    logic [7:0]  poll_interval;
  } cfg_regs_t;

endpackage

// ===== rtl/usbhid_stream_if.sv =====
interface usbhid_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/usbhid_desc_rom.sv =====
// Descriptor image lookup: eight bytes of one packet window, zero past the end.
module usbhid_desc_rom (
  input  logic [3:0]             kind,
  input  logic [2:0]             packet_index,
  input  usbhid_pkg::cfg_regs_t  regs,
  output logic [63:0]            window,
  output logic [5:0]             length
);
  import usbhid_pkg::*;

  function automatic logic [5:0] desc_len(input logic [3:0] k);
    logic [5:0] len;
    unique case (k)
      ST_DEVICE:   len = LEN_DEVICE;
      ST_CFG_FULL: len = LEN_CFG_FULL;
      ST_CFG_HEAD: len = LEN_CFG_HEAD;
      ST_STR0:     len = LEN_STR0;
      ST_STR1:     len = LEN_STR1;
      ST_STR2:     len = LEN_STR2;
      ST_STR3:     len = LEN_STR3;
      ST_REPORT:   len = LEN_REPORT;
      default:     len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] desc_byte(input logic [3:0] k, input logic [5:0] addr,
                                           input cfg_regs_t r);
    logic [7:0] b;
    logic [4:0] ch;
    b  = '0;
    ch = addr[5:1] - 5'd1;  // character slot of a string descriptor
    if (addr < desc_len(k)) begin
      unique case (k) inside
        ST_DEVICE: begin
          case (addr)
            6'd8:    b = r.vendor_id[7:0];
            6'd9:    b = r.vendor_id[15:8];
            6'd10:   b = r.product_id[7:0];
            6'd11:   b = r.product_id[15:8];
            default: b = DEV_ROM[addr[4:0]];
          endcase
        end
        ST_CFG_FULL, ST_CFG_HEAD: begin
          case (addr)
            6'd8:    b = r.max_power;
            6'd33:   b = r.poll_interval;
            default: b = CFG_ROM[addr];
          endcase
        end
        ST_STR0: begin
          case (addr)
            6'd0:    b = 8'(LEN_STR0);
            6'd1:    b = DT_STRING;
            6'd2:    b = 8'h09;
            default: b = 8'h04;
          endcase
        end
        ST_STR1, ST_STR2, ST_STR3: begin
          if (addr == 6'd0) begin
            b = 8'(desc_len(k));
          end else if (addr == 6'd1) begin
            b = DT_STRING;
          end else if (!addr[0]) begin
            case (k)
              ST_STR1: b = TEXT1[ch[3:0]];
              ST_STR2: b = TEXT2[ch];
              default: b = TEXT3[ch[3:0]];
            endcase
          end
        end
        ST_REPORT: b = REPORT_ROM[addr];
        default:   b = '0;
      endcase
    end
    return b;
  endfunction

  assign length = desc_len(kind);

  always_comb begin
    for (int k = 0; k < CONTROL_PACKET_BYTES; k++) begin
      window[8*k +: 8] = desc_byte(kind, {packet_index, 3'(k)}, regs);
    end
  end

endmodule

// ===== rtl/usb_hid_mouse_control_endpoint.sv =====
// Endpoint-0 control transfer engine for a HID mouse.
// req (sink): one item per endpoint-0 interrupt, carrying the status flags
//   and the decoded setup packet fields.
// rsp (source): exactly one item per req item: the IN packet (up to eight
//   descriptor bytes), flag clears, address write and configuration status.
// cfg_write_en/cfg_index/cfg_data: register writes (vendor id, product id,
//   max power, poll interval), to be written by the user only while no item is
//   in flight; the block itself leaves enforcing this to the user. A req item
//   accepted into the input register is loaded into the result register and
//   then offered on rsp (input register, then result register).
// Throughput: one item per cycle while rsp does not stall; the single state
//   update plus descriptor ROM window read sets this.
// Reset (synchronous, rst high): idle, packet index 0, not configured,
//   configuration 0, registers at their defaults, both channels empty.
// When rsp stalls, the result register holds and the input register can still
//   take one item; req.ready drops only when both are full.
module usb_hid_mouse_control_endpoint (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  usbhid_stream_if.sink            req,
  usbhid_stream_if.source          rsp
);
  import usbhid_pkg::*;

  // configuration registers
  cfg_regs_t regs;

  // input stage
  logic s1_valid;
  req_t s1;
  logic adv;  // input stage moves into the result register

  // endpoint state
  logic [3:0] state, state_next;
  logic [2:0] packet_index, packet_index_next;
  logic       is_configured, is_configured_next;
  logic [7:0] chosen_cfg, chosen_cfg_next;

  // result register
  logic rsp_valid;
  rsp_t rsp_q;
  rsp_t result;

  // decode stage signals
  logic       abort;
  logic [3:0] st_mid;  // state after the setup decode, before streaming
  logic       dec_clear_out_ready;
  logic       dec_stage_end;
  logic       dec_address_write;
  logic [7:0] dec_device_address;

  // stream signals
  logic [63:0] window;
  logic [5:0]  desc_length;
  logic [5:0]  offset;
  logic        last_packet;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{vendor_id: VENDOR_ID_RESET, product_id: PRODUCT_ID_RESET,
                max_power: MAX_POWER_RESET, poll_interval: POLL_INTERVAL_RESET};
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_VENDOR_ID:     regs.vendor_id     <= cfg_data;
        REG_PRODUCT_ID:    regs.product_id    <= cfg_data;
        REG_MAX_POWER:     regs.max_power     <= cfg_data[7:0];
        REG_POLL_INTERVAL: regs.poll_interval <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv       = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1 <= req.data;
    end
  end

  // Setup decode. Flags abort any transfer; a setup packet is only read idle.
  assign abort = s1.early_end || s1.sent_stall;

  always_comb begin
    st_mid              = state;
    dec_clear_out_ready = 1'b0;
    dec_stage_end       = 1'b0;
    dec_address_write   = 1'b0;
    dec_device_address  = '0;
    is_configured_next  = is_configured;
    chosen_cfg_next     = chosen_cfg;
    if (abort) begin
      st_mid              = ST_IDLE;
      dec_clear_out_ready = s1.out_ready;
    end else if (s1.out_ready && state == ST_IDLE) begin
      if (s1.request_type[6:5] == RT_CLASS && s1.request_code == RQ_SET_IDLE) begin
        dec_clear_out_ready = 1'b1;
        dec_stage_end       = 1'b1;
      end else if (s1.request_type[6:5] == RT_STANDARD) begin
        unique case (s1.request_code)
          RQ_GET_DESCRIPTOR: begin
            unique case (s1.value_high)
              DT_DEVICE: begin
                dec_clear_out_ready = 1'b1;
                st_mid              = ST_DEVICE;
              end
              DT_CONFIG: begin
                dec_clear_out_ready = 1'b1;
                st_mid = (s1.request_length > CFG_HEAD_LEN) ? ST_CFG_FULL : ST_CFG_HEAD;
              end
              DT_STRING: begin
                // unknown string index: acknowledged, nothing sent
                dec_clear_out_ready = 1'b1;
                if (s1.value_low <= 8'd3) begin
                  st_mid = ST_STR0 + {2'b00, s1.value_low[1:0]};
                end
              end
              DT_REPORT: begin
                dec_clear_out_ready = 1'b1;
                st_mid              = ST_REPORT;
              end
              default: ;
            endcase
          end
          RQ_SET_ADDRESS: begin
            dec_address_write   = 1'b1;
            dec_device_address  = s1.value_low | ADDR_ENABLE;
            dec_clear_out_ready = 1'b1;
            dec_stage_end       = 1'b1;
          end
          RQ_SET_CONFIGURATION: begin
            chosen_cfg_next     = s1.value_low;
            is_configured_next  = 1'b1;
            dec_clear_out_ready = 1'b1;
            dec_stage_end       = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  usbhid_desc_rom u_rom (
    .kind         (st_mid),
    .packet_index (packet_index),
    .regs         (regs),
    .window       (window),
    .length       (desc_length)
  );

  // Packet selection. The state is idle between transfers, so the index is
  // already zero when a new descriptor starts.
  assign offset      = {packet_index, 3'b000};
  assign last_packet = !(({1'b0, offset} + 7'(CONTROL_PACKET_BYTES)) < {1'b0, desc_length});

  always_comb begin
    result                  = '0;
    result.clear_out_ready  = dec_clear_out_ready;
    result.clear_early_end  = s1.early_end;
    result.clear_sent_stall = s1.sent_stall && !s1.early_end;
    result.address_write    = dec_address_write;
    result.device_address   = dec_device_address;
    result.stage_end        = dec_stage_end;
    state_next              = st_mid;
    packet_index_next       = abort ? 3'd0 : packet_index;
    if (!abort && st_mid != ST_IDLE) begin
      result.send_packet = 1'b1;
      result.packet_data = window;  // ROM reads zero past the end
      if (last_packet) begin
        result.packet_bytes = (offset < desc_length) ? 4'(desc_length - offset) : 4'd0;
        result.stage_end    = 1'b1;
        state_next          = ST_IDLE;
        packet_index_next   = 3'd0;
      end else begin
        result.packet_bytes = 4'(CONTROL_PACKET_BYTES);
        packet_index_next   = packet_index + 3'd1;
      end
    end
    result.configured   = is_configured_next;
    result.config_value = chosen_cfg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      packet_index  <= '0;
      is_configured <= 1'b0;
      chosen_cfg    <= '0;
    end else if (adv) begin
      state         <= state_next;
      packet_index  <= packet_index_next;
      is_configured <= is_configured_next;
      chosen_cfg    <= chosen_cfg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_q <= result;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

endmodule

// ===== rtl/usbhid_checker.sv =====
`include "assert_macros.svh"

module usbhid_checker (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input usbhid_pkg::rsp_t  rsp_data
);
  import usbhid_pkg::*;

  logic is_stall;
  logic pkt_empty;
  logic short_pkt;
  logic addr_ok;
  logic flag_clear;
  logic abort_ok;

  assign is_stall   = rsp_valid && !rsp_ready;
  assign pkt_empty  = rsp_data.packet_bytes == 4'd0 && rsp_data.packet_data == 64'd0;
  assign short_pkt  = rsp_valid && rsp_data.send_packet && rsp_data.packet_bytes != 4'd8;
  assign addr_ok    = rsp_data.device_address[7] && rsp_data.clear_out_ready &&
                      !rsp_data.send_packet;
  assign flag_clear = rsp_data.clear_early_end || rsp_data.clear_sent_stall;
  assign abort_ok   = !(rsp_data.clear_early_end && rsp_data.clear_sent_stall) &&
                      !rsp_data.send_packet;

  // a stalled result holds
  `CHK_NEXT(a_rsp_hold, clk, rst, is_stall, rsp_valid && $stable(rsp_data))

  // nothing sent means an empty packet
  `CHK_IMPLY(a_empty_packet, clk, rst, rsp_valid && !rsp_data.send_packet, pkt_empty)

  // a short packet always closes the data stage
  `CHK_IMPLY(a_short_ends, clk, rst, short_pkt, rsp_data.stage_end)

  // an address write acknowledges the setup and carries the enable bit
  `CHK_IMPLY(a_address, clk, rst, rsp_valid && rsp_data.address_write, addr_ok)

  // an abort clears one flag and sends nothing
  `CHK_IMPLY(a_abort, clk, rst, rsp_valid && flag_clear, abort_ok)

endmodule

bind usb_hid_mouse_control_endpoint usbhid_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
